// ----- hdl/cpsa_pkg.sv -----
// types, constants and the preset glyph table of the code point slot allocator
package cpsa_pkg;

	localparam int FONT_BITS   = 8;
	localparam int PRESET_LO   = 33;
	localparam int PRESET_HI   = 133;
	localparam int APPEND_INIT = 134;
	localparam int LIG_BASE    = 127;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_RD_ISSUE,
		ST_RD_DATA,
		ST_DONE
	} cpsa_state_t;

	typedef enum logic {
		KIND_ASSIGN = 1'b0,
		KIND_READ   = 1'b1
	} cpsa_kind_t;

	// code held by a preset slot after reset, valid for slots 33..133
	function automatic logic [15:0] preset_code(input logic [7:0] s);
		logic [15:0] c;
		c = 16'h0000;
		if (s < 8'(LIG_BASE)) begin
			c = {8'h00, s};
		end else begin
			case (s)
				8'd127:  c = 16'hFB00;
				8'd128:  c = 16'hFB01;
				8'd129:  c = 16'hFB02;
				8'd130:  c = 16'hFB03;
				8'd131:  c = 16'hFB04;
				8'd132:  c = 16'h2013;
				8'd133:  c = 16'h2014;
				default: c = 16'h0000;
			endcase
		end
		return c;
	endfunction

endpackage

// ----- hdl/cpsa_if.sv -----
// request and response channel interfaces of the code point slot allocator
interface cpsa_req_if;
	logic        valid;
	logic        ready;
	logic [0:0]  kind;
	logic [15:0] code_point;
	logic [1:0]  font_index;
	logic [7:0]  char_code;

	modport source (output valid, kind, code_point, font_index, char_code, input ready);
	modport sink (input valid, kind, code_point, font_index, char_code, output ready);
endinterface

interface cpsa_rsp_if;
	logic        valid;
	logic        ready;
	logic [9:0]  slot_index;
	logic [1:0]  font_number;
	logic [7:0]  glyph_position;
	logic [15:0] code_read;
	logic [2:0]  font_count;
	logic        table_full;

	modport source (output valid, slot_index, font_number, glyph_position, code_read,
		font_count, table_full, input ready);
	modport sink (input valid, slot_index, font_number, glyph_position, code_read,
		font_count, table_full, output ready);
endinterface

// ----- hdl/code_point_slot_allocator.sv -----
// top level: glyph slot dictionary with a scanned slot memory
// usage
//   req carries one transaction per item: kind 0 looks up or assigns code_point,
//   kind 1 reads the code stored at font_index / char_code
//   rsp returns one transaction per item: slot, font, position, code read,
//   font count after the item, and the table full flag
// scanning
//   an assign scans the slots below the append pointer, one memory read per
//   cycle, and stops at the first hit or, on a miss, after the last slot
//   below the append pointer; a read item reads the one addressed slot
//   req is ready again the cycle after the result is loaded; one item is in
//   flight at a time
// reset
//   arst_n resets the fill counters at once; which slots are in use follows
//   from the counters and the fixed preset range, and preset codes come from a
//   constant table, so no clearing pass runs and req is ready right after reset
// stalls
//   a finished result sits in the rsp register; while rsp is stalled the next
//   item is still taken and worked on, and it waits for the register to drain
module code_point_slot_allocator
	import cpsa_pkg::*;
#(
	parameter int CAPACITY  = 1024,
	parameter int LOW_SLOTS = 33
) (
	input  logic             clk,
	input  logic             arst_n,
	cpsa_req_if.sink         req,
	cpsa_rsp_if.source       rsp
);

	localparam int AW = $clog2(CAPACITY);
	localparam int IW = (AW > 10) ? AW : 10;
	localparam int CW = IW + 1;

	// slot memory, content only meaningful where the slot is in use
	logic [15:0] mem [CAPACITY];

	cpsa_state_t state_q, state_d;
	cpsa_kind_t  kind_q;
	logic [15:0] cp_q;
	logic [9:0]  idx_q;
	logic [AW:0] scan_q, scan_d;
	logic        pend_s1, pend_d;
	logic [AW-1:0] tag_s1;
	logic [15:0] rdata_s1;
	logic [5:0]  low_q, low_d;
	logic [AW:0] append_q, append_d;
	logic [AW-1:0] res_slot_q, res_slot_d;
	logic [15:0] res_code_q, res_code_d;
	logic        res_full_q, res_full_d;
	logic        res_load;

	logic        rd_en;
	logic [AW-1:0] rd_addr;
	logic        wr_en;
	logic [AW-1:0] wr_addr;
	logic        req_acc;

	logic        out_valid_q;
	logic [9:0]  out_slot_q;
	logic [1:0]  out_font_q;
	logic [7:0]  out_pos_q;
	logic [15:0] out_code_q;
	logic [2:0]  out_fc_q;
	logic        out_full_q;

	// a slot is in use below the low fill count, in the preset range, or
	// between the preset range and the append pointer
	function automatic logic slot_used(input logic [CW-1:0] a, input logic [5:0] lf,
		input logic [AW:0] ap);
		logic [CW-1:0] lf_w;
		logic [CW-1:0] ap_w;
		lf_w = CW'(lf);
		ap_w = CW'(ap);
		return (a < lf_w) || (a >= CW'(PRESET_LO) && a <= CW'(PRESET_HI))
			|| (a >= CW'(APPEND_INIT) && a < ap_w);
	endfunction

	function automatic logic is_preset(input logic [CW-1:0] a);
		return a >= CW'(PRESET_LO) && a <= CW'(PRESET_HI);
	endfunction

	logic [CW-1:0] tag_w;
	logic [CW-1:0] idx_w;
	logic [15:0]   tag_code;
	logic          hit;
	logic [CW-1:0] ap_w;
	logic [IW-1:0] res_sw;

	assign tag_w    = CW'(tag_s1);
	assign idx_w    = CW'(idx_q);
	assign tag_code = is_preset(tag_w) ? preset_code(tag_s1[7:0]) : rdata_s1;
	assign hit      = pend_s1 && slot_used(tag_w, low_q, append_q) && (tag_code == cp_q);
	assign ap_w     = CW'(append_q);
	assign res_sw   = IW'(res_slot_q);

	assign req.ready = (state_q == ST_IDLE);
	assign req_acc   = req.valid && req.ready;

	// next state, memory control and result capture
	always_comb begin
		state_d    = state_q;
		scan_d     = scan_q;
		pend_d     = 1'b0;
		low_d      = low_q;
		append_d   = append_q;
		res_slot_d = res_slot_q;
		res_code_d = res_code_q;
		res_full_d = res_full_q;
		rd_en      = 1'b0;
		rd_addr    = scan_q[AW-1:0];
		wr_en      = 1'b0;
		wr_addr    = AW'(low_q);
		res_load   = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (req_acc) begin
					scan_d     = '0;
					res_slot_d = '0;
					res_code_d = '0;
					res_full_d = 1'b0;
					state_d    = (cpsa_kind_t'(req.kind) == KIND_READ) ? ST_RD_ISSUE : ST_SCAN;
				end
			end
			ST_SCAN: begin
				// issue one read a cycle, compare the previous one
				if (scan_q < append_q) begin
					rd_en   = 1'b1;
					rd_addr = scan_q[AW-1:0];
					scan_d  = scan_q + 1'b1;
					pend_d  = 1'b1;
				end
				if (hit) begin
					res_slot_d = tag_s1;
					state_d    = ST_DONE;
				end else if (!pend_s1 && scan_q >= append_q) begin
					// code point absent: allocate a slot, or flag the table full
					state_d = ST_DONE;
					if (low_q < 6'(LOW_SLOTS)) begin
						wr_en      = 1'b1;
						wr_addr    = AW'(low_q);
						res_slot_d = AW'(low_q);
						low_d      = low_q + 6'd1;
					end else if (append_q < (AW+1)'(CAPACITY)) begin
						wr_en      = 1'b1;
						wr_addr    = append_q[AW-1:0];
						res_slot_d = append_q[AW-1:0];
						append_d   = append_q + 1'b1;
					end else begin
						res_full_d = 1'b1;
						res_slot_d = '0;
					end
				end
			end
			ST_RD_ISSUE: begin
				rd_en   = idx_w < CW'(CAPACITY);
				rd_addr = AW'(idx_w);
				state_d = ST_RD_DATA;
			end
			ST_RD_DATA: begin
				if (idx_w < CW'(CAPACITY) && slot_used(idx_w, low_q, append_q)) begin
					res_code_d = is_preset(idx_w) ? preset_code(idx_q[7:0]) : rdata_s1;
				end
				state_d = ST_DONE;
			end
			ST_DONE: begin
				if (!out_valid_q || rsp.ready) begin
					res_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			pend_s1  <= 1'b0;
			low_q    <= '0;
			append_q <= (AW+1)'(APPEND_INIT);
		end else begin
			state_q  <= state_d;
			pend_s1  <= pend_d;
			low_q    <= low_d;
			append_q <= append_d;
		end
	end

	// item payload and scan datapath
	always_ff @(posedge clk) begin
		if (req_acc) begin
			kind_q <= cpsa_kind_t'(req.kind);
			cp_q   <= req.code_point;
			idx_q  <= {req.font_index, req.char_code};
		end
		scan_q     <= scan_d;
		tag_s1     <= rd_addr;
		res_slot_q <= res_slot_d;
		res_code_q <= res_code_d;
		res_full_q <= res_full_d;
	end

	// slot memory: one read port, one write port, registered read data
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= cp_q;
		end
		if (rd_en) begin
			rdata_s1 <= mem[rd_addr];
		end
	end

	// response register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_load) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			out_slot_q <= res_sw[9:0];
			out_font_q <= res_sw[9:8];
			out_pos_q  <= res_sw[7:0];
			out_code_q <= (kind_q == KIND_READ) ? res_code_q : 16'h0000;
			out_fc_q   <= 3'(ap_w >> FONT_BITS) + 3'd1;
			out_full_q <= res_full_q;
		end
	end

	assign rsp.valid          = out_valid_q;
	assign rsp.slot_index     = out_slot_q;
	assign rsp.font_number    = out_font_q;
	assign rsp.glyph_position = out_pos_q;
	assign rsp.code_read      = out_code_q;
	assign rsp.font_count     = out_fc_q;
	assign rsp.table_full     = out_full_q;

`ifndef ASSERT_OFF
	a_low_bound: assert property (@(posedge clk) disable iff (!arst_n)
		low_q <= 6'(LOW_SLOTS))
		else $error("low fill count beyond low slot range");

	a_append_bound: assert property (@(posedge clk) disable iff (!arst_n)
		append_q >= (AW+1)'(APPEND_INIT) && append_q <= (AW+1)'(CAPACITY))
		else $error("append pointer out of range");

	a_append_step: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(append_q) |-> append_q == $past(append_q) + 1'b1)
		else $error("append pointer moved by more than one");

	a_full_only_when_exhausted: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE && res_full_q) |->
		(low_q == 6'(LOW_SLOTS) && append_q == (AW+1)'(CAPACITY)))
		else $error("table full reported while a slot is free");

	a_single_write: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |=> state_q == ST_DONE && !wr_en)
		else $error("slot written more than once per item");
`endif

endmodule
